// ----- rtl/chunked_slot_allocator_swap_remove_core_defines.svh -----
// assertion macros for the chunked slot allocator core
// expects clk and rst_n in the scope where a macro is used
`ifndef CHUNKED_SLOT_ALLOCATOR_SWAP_REMOVE_CORE_DEFINES_SVH
`define CHUNKED_SLOT_ALLOCATOR_SWAP_REMOVE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/csa_pkg.sv -----
// shared constants and codes of the chunked slot allocator
// no dependencies
package csa_pkg;

    localparam int MAX_CHUNKS   = 16;
    localparam int MAX_COLUMNS  = 64;
    localparam int ENTITY_W     = 32;

    localparam int CHUNK_W      = $clog2(MAX_CHUNKS);
    localparam int COL_W        = $clog2(MAX_COLUMNS);
    localparam int CNT_W        = $clog2(MAX_COLUMNS + 1);
    localparam int DEPTH_W      = $clog2(MAX_CHUNKS + 1);
    localparam int ADDR_W       = CHUNK_W + COL_W;
    localparam int STORE_DEPTH  = MAX_CHUNKS * MAX_COLUMNS;

    localparam int ARCH_W       = 16;
    localparam int CAP_W        = 7;
    localparam int STATUS_W     = 2;

    // stream payload sizes, padded to whole bytes
    localparam int IN_BITS      = ENTITY_W + ARCH_W + CHUNK_W + COL_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = STATUS_W + ARCH_W + CHUNK_W + COL_W + 1 + ENTITY_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ARCHETYPE = 1'b1;
    localparam logic [CAP_W-1:0]     CAPACITY_RESET = 7'd16;

    // commands
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CHUNK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LOC  = 2'd2;

endpackage

// ----- rtl/csa_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module csa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/chunked_slot_allocator_swap_remove_core.sv -----
// top level of the chunked slot allocator with swap-remove
// depends on csa_pkg, csa_ram and the assertion macro header
`include "chunked_slot_allocator_swap_remove_core_defines.svh"

// Keeps entity ids densely packed in MAX_CHUNKS chunks of up to chunk_capacity
// columns. An add takes the chunk on top of a stack of non-full chunks (opening
// a new chunk when the stack is empty) and returns archetype, chunk and column;
// a remove checks the location and moves the chunk's last entity into the freed
// column, reporting it. Each item has an accept and an execute cycle: the accept
// cycle issues the entity ram read (address = chunk and its last column), the
// execute cycle consumes the registered read data, writes back and loads the
// result register. The execute cycle waits while a previous result sits
// unclaimed in the output register. A new item is accepted only after the
// previous one has executed, so ram and count accesses never overlap. The
// entity ram is not cleared after reset; column counts, the stack depth and
// the opened-chunk count reset to zero.
module chunked_slot_allocator_swap_remove_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // entity_id, loc_archetype, loc_chunk, loc_column, zero pad
    input  logic [csa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd
    input  logic [0:0]                         s_axis_tuser,
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status, out_archetype, out_chunk, out_column, moved_valid, moved_entity, zero pad
    output logic [csa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [csa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import csa_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // control state
    logic                state_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [DEPTH_W-1:0]  opened_reg;
    logic [CNT_W-1:0]    count_reg [MAX_CHUNKS];
    logic [CHUNK_W-1:0]  stack_reg [MAX_CHUNKS];
    logic [CAP_W-1:0]    cap_reg;
    logic [ARCH_W-1:0]   arch_reg;

    // captured item
    logic                cmd_reg;
    logic [ENTITY_W-1:0] entity_reg;
    logic [ARCH_W-1:0]   loc_arch_reg;
    logic [CHUNK_W-1:0]  loc_chunk_reg;
    logic [COL_W-1:0]    loc_col_reg;

    // result register
    logic                m_valid_reg;
    logic [STATUS_W-1:0] st_out_reg;
    logic [ARCH_W-1:0]   arch_out_reg;
    logic [CHUNK_W-1:0]  chunk_out_reg;
    logic [COL_W-1:0]    col_out_reg;
    logic                mv_out_reg;
    logic [ENTITY_W-1:0] ment_out_reg;

    // input fields
    logic [ENTITY_W-1:0] in_entity;
    logic [ARCH_W-1:0]   in_arch;
    logic [CHUNK_W-1:0]  in_chunk;
    logic [COL_W-1:0]    in_col;
    logic [CNT_W-1:0]    in_last;

    logic s_fire;
    logic fire;

    // entity ram
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTITY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTITY_W-1:0] ram_rdata;

    // execute-cycle decode
    logic [CNT_W-1:0]    cap_eff;
    logic                stack_empty;
    logic [CHUNK_W-1:0]  add_chunk;
    logic [CNT_W-1:0]    add_col;
    logic                add_no_chunk;
    logic                add_stale;
    logic                add_ok;
    logic [CNT_W-1:0]    rm_cnt;
    logic [CNT_W-1:0]    rm_last;
    logic                rm_bad;
    logic                rm_move;
    logic                rm_was_full;

    // state updates decided in the execute cycle
    logic                cnt_we;
    logic [CHUNK_W-1:0]  cnt_idx;
    logic [CNT_W-1:0]    cnt_wval;
    logic                stk_we;
    logic [CHUNK_W-1:0]  stk_idx;
    logic [CHUNK_W-1:0]  stk_wval;
    logic [DEPTH_W-1:0]  depth_next;
    logic [DEPTH_W-1:0]  opened_next;

    // result of the execute cycle
    logic [STATUS_W-1:0] res_st;
    logic [ARCH_W-1:0]   res_arch;
    logic [CHUNK_W-1:0]  res_chunk;
    logic [COL_W-1:0]    res_col;
    logic                res_mv;
    logic [ENTITY_W-1:0] res_ment;

    // unpack input payload
    assign in_entity = s_axis_tdata[ENTITY_W-1:0];
    assign in_arch   = s_axis_tdata[ENTITY_W +: ARCH_W];
    assign in_chunk  = s_axis_tdata[ENTITY_W + ARCH_W +: CHUNK_W];
    assign in_col    = s_axis_tdata[ENTITY_W + ARCH_W + CHUNK_W +: COL_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    // execute once the output register is free or being emptied
    assign fire          = (state_reg == ST_EXEC) && (!m_valid_reg || m_axis_tready);

    // on accept, prefetch the last entity of the addressed chunk for a remove
    assign in_last   = count_reg[in_chunk] - CNT_W'(1);
    assign ram_raddr = {in_chunk, in_last[COL_W-1:0]};

    csa_ram #(
        .WIDTH (ENTITY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_fire),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // capacity clamped to 1..MAX_COLUMNS
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CAP_W'(MAX_COLUMNS))
        begin
            cap_eff = CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    // add path: top of stack, or a freshly opened chunk
    assign stack_empty  = (depth_reg == '0);
    assign add_chunk    = stack_empty ? opened_reg[CHUNK_W-1:0]
                                      : stack_reg[CHUNK_W'(depth_reg - DEPTH_W'(1))];
    assign add_col      = stack_empty ? '0 : count_reg[add_chunk];
    assign add_no_chunk = stack_empty && (opened_reg >= DEPTH_W'(MAX_CHUNKS));
    // capacity lowered under a stacked chunk
    assign add_stale    = !stack_empty && (add_col >= cap_eff);
    assign add_ok       = !add_no_chunk && !add_stale;

    // remove path
    assign rm_cnt      = count_reg[loc_chunk_reg];
    assign rm_last     = rm_cnt - CNT_W'(1);
    assign rm_bad      = (loc_arch_reg != arch_reg)
                      || (DEPTH_W'(loc_chunk_reg) >= opened_reg)
                      || (CNT_W'(loc_col_reg) >= rm_cnt);
    assign rm_move     = (CNT_W'(loc_col_reg) != rm_last);
    assign rm_was_full = (rm_cnt == cap_eff);

    always_comb
    begin
        cnt_we      = 1'b0;
        cnt_idx     = add_chunk;
        cnt_wval    = add_col + CNT_W'(1);
        stk_we      = 1'b0;
        stk_idx     = '0;
        stk_wval    = add_chunk;
        depth_next  = depth_reg;
        opened_next = opened_reg;
        ram_we      = 1'b0;
        ram_waddr   = {add_chunk, add_col[COL_W-1:0]};
        ram_wdata   = entity_reg;
        res_st      = ST_OK;
        res_arch    = '0;
        res_chunk   = '0;
        res_col     = '0;
        res_mv      = 1'b0;
        res_ment    = '0;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (add_no_chunk)
                begin
                    res_st = ST_NO_CHUNK;
                end
                else if (add_stale)
                begin
                    res_st     = ST_NO_CHUNK;
                    depth_next = depth_reg - DEPTH_W'(1);
                end
                else
                begin
                    cnt_we    = 1'b1;
                    ram_we    = fire;
                    res_arch  = arch_reg;
                    res_chunk = add_chunk;
                    res_col   = add_col[COL_W-1:0];
                    if (stack_empty)
                    begin
                        // open a new chunk as the only stack entry
                        stk_we      = 1'b1;
                        opened_next = opened_reg + DEPTH_W'(1);
                        depth_next  = DEPTH_W'(1);
                    end
                    // chunk filled up: drop it from the stack
                    if (add_col + CNT_W'(1) >= cap_eff)
                    begin
                        depth_next = depth_next - DEPTH_W'(1);
                    end
                end
            end
            CMD_REMOVE:
            begin
                if (rm_bad)
                begin
                    res_st = ST_BAD_LOC;
                end
                else
                begin
                    cnt_we    = 1'b1;
                    cnt_idx   = loc_chunk_reg;
                    cnt_wval  = rm_last;
                    ram_waddr = {loc_chunk_reg, loc_col_reg};
                    ram_wdata = ram_rdata;
                    ram_we    = fire && rm_move;
                    res_mv    = rm_move;
                    res_ment  = rm_move ? ram_rdata : '0;
                    // full chunk gets room again, push it while the stack has space
                    if (rm_was_full && (depth_reg < DEPTH_W'(MAX_CHUNKS)))
                    begin
                        stk_we     = 1'b1;
                        stk_idx    = depth_reg[CHUNK_W-1:0];
                        stk_wval   = loc_chunk_reg;
                        depth_next = depth_reg + DEPTH_W'(1);
                    end
                end
            end
            default:
            begin
                res_st = ST_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            opened_reg  <= '0;
            m_valid_reg <= 1'b0;
            cap_reg     <= CAPACITY_RESET;
            arch_reg    <= '0;
            for (int i = 0; i < MAX_CHUNKS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CAPACITY:  cap_reg  <= cfg_data[CAP_W-1:0];
                    REG_ARCHETYPE: arch_reg <= cfg_data[ARCH_W-1:0];
                    default:       arch_reg <= arch_reg;
                endcase
            end
            if (s_fire)
            begin
                state_reg <= ST_EXEC;
            end
            else if (fire)
            begin
                state_reg <= ST_IDLE;
            end
            if (fire)
            begin
                m_valid_reg <= 1'b1;
                depth_reg   <= depth_next;
                opened_reg  <= opened_next;
                if (cnt_we)
                begin
                    count_reg[cnt_idx] <= cnt_wval;
                end
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg       <= s_axis_tuser[0];
            entity_reg    <= in_entity;
            loc_arch_reg  <= in_arch;
            loc_chunk_reg <= in_chunk;
            loc_col_reg   <= in_col;
        end
        if (fire)
        begin
            st_out_reg    <= res_st;
            arch_out_reg  <= res_arch;
            chunk_out_reg <= res_chunk;
            col_out_reg   <= res_col;
            mv_out_reg    <= res_mv;
            ment_out_reg  <= res_ment;
            if (stk_we)
            begin
                stack_reg[stk_idx] <= stk_wval;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, ment_out_reg, mv_out_reg,
                            col_out_reg, chunk_out_reg, arch_out_reg, st_out_reg};

    // stack depth and opened count never pass the chunk total
    `CSA_ASSERT_SAME(a_depth_bound, 1'b1, (depth_reg <= DEPTH_W'(MAX_CHUNKS)) && (opened_reg <= DEPTH_W'(MAX_CHUNKS)), "stack depth or opened count out of range")
    // every accepted item moves the core into the execute state
    `CSA_ASSERT_NEXT(a_accept_exec, s_fire, state_reg == ST_EXEC, "accepted item did not enter execute")
    // a result only appears after an execute cycle
    `CSA_ASSERT_SAME(a_result_src, $rose(m_axis_tvalid), $past(state_reg == ST_EXEC), "result without execute")
    // a reported move always belongs to a successful remove
    `CSA_ASSERT_SAME(a_move_ok, m_valid_reg && mv_out_reg, (st_out_reg == ST_OK) && (arch_out_reg == '0), "moved entity on a failed or add result")

endmodule

// ----- verif/chunked_slot_allocator_swap_remove_core_tb.sv -----
// self-checking testbench for the chunked slot allocator core with swap-remove
// depends on csa_pkg and the core rtl; a built-in predictor tracks chunks and stack
module chunked_slot_allocator_swap_remove_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csa_pkg::*;

    // one reply of the allocator, fields in the order they sit in m_axis_tdata
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ARCH_W-1:0]   arch;
        logic [CHUNK_W-1:0]  chunk;
        logic [COL_W-1:0]    column;
        logic                moved;
        logic [ENTITY_W-1:0] moved_id;
    } slot_reply_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // entity_id, loc_archetype, loc_chunk, loc_column, zero pad
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // cmd
    logic [0:0]              s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // status, out_archetype, out_chunk, out_column, moved_valid, moved_entity, zero pad
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // predictor state: our own copy of the chunk table, stack and registers
    logic [ENTITY_W-1:0]     slot_ids [STORE_DEPTH];
    int                      fill_count [MAX_CHUNKS];
    int                      open_stack [MAX_CHUNKS];
    int                      open_depth;
    int                      chunks_used;
    logic [CAP_W-1:0]        cap_reg;
    logic [ARCH_W-1:0]       arch_reg;

    // replies predicted for accepted items, oldest first
    slot_reply_t             pending_replies [$];

    // per-cycle idle chances, in percent
    int                      tx_idle_pct;
    int                      rx_idle_pct;

    int                      error_count;
    int                      items_sent;
    int                      placed_count;
    int                      removed_count;
    int                      swap_count;
    int                      full_count;
    int                      bad_loc_count;

    chunked_slot_allocator_swap_remove_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 4 ns clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #2_000_000;
        $display("timeout: %0d replies still outstanding", pending_replies.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one line per mismatch, only the first 30 are printed
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= 30)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
    endtask

    // predictor: applies one command to the shadow state and returns the reply
    function automatic slot_reply_t apply_slot_command(input logic cmd,
                                                       input logic [ENTITY_W-1:0] id,
                                                       input logic [ARCH_W-1:0] loc_arch,
                                                       input logic [CHUNK_W-1:0] loc_chunk,
                                                       input logic [COL_W-1:0] loc_col);
        slot_reply_t r;
        int          cap;
        int          ch;
        int          col;
        int          last;
        logic        was_full;
        r = '0;
        // capacity 0 behaves as 1, anything above the column count saturates
        cap = (cap_reg == 0) ? 1 : ((cap_reg > MAX_COLUMNS) ? MAX_COLUMNS : int'(cap_reg));
        if (cmd == CMD_ADD)
        begin
            if (open_depth == 0)
            begin
                // every chunk opened and none has room: out of space
                if (chunks_used >= MAX_CHUNKS)
                begin
                    r.status = ST_NO_CHUNK;
                    return r;
                end
                fill_count[chunks_used] = 0;
                open_stack[0] = chunks_used;
                open_depth = 1;
                chunks_used++;
            end
            ch = open_stack[open_depth - 1];
            col = fill_count[ch];
            // top chunk went stale after a capacity drop: pop it, place nothing
            if (col >= cap)
            begin
                open_depth--;
                r.status = ST_NO_CHUNK;
                return r;
            end
            slot_ids[ch * MAX_COLUMNS + col] = id;
            fill_count[ch] = col + 1;
            if (col + 1 >= cap)
                open_depth--;
            r.status = ST_OK;
            r.arch = arch_reg;
            r.chunk = CHUNK_W'(ch);
            r.column = COL_W'(col);
        end
        else
        begin
            if (loc_arch != arch_reg || int'(loc_chunk) >= chunks_used
                || int'(loc_col) >= fill_count[loc_chunk])
            begin
                r.status = ST_BAD_LOC;
                return r;
            end
            ch = int'(loc_chunk);
            was_full = (fill_count[ch] == cap);
            last = fill_count[ch] - 1;
            // swap-remove: the last entity of the chunk fills the hole
            if (int'(loc_col) != last)
            begin
                r.moved = 1'b1;
                r.moved_id = slot_ids[ch * MAX_COLUMNS + last];
                slot_ids[ch * MAX_COLUMNS + int'(loc_col)] = r.moved_id;
            end
            fill_count[ch] = last;
            // a chunk leaving the full state goes back on the stack, if it fits
            if (was_full && open_depth < MAX_CHUNKS)
            begin
                open_stack[open_depth] = ch;
                open_depth++;
            end
            r.status = ST_OK;
        end
        return r;
    endfunction

    // sends one item, waits for it to be taken, then queues the predicted reply
    task automatic send_command(input logic cmd, input logic [ENTITY_W-1:0] id,
                                input logic [ARCH_W-1:0] loc_arch,
                                input logic [CHUNK_W-1:0] loc_chunk,
                                input logic [COL_W-1:0] loc_col);
        slot_reply_t r;
        // random sender gaps ahead of the item
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {{(IN_TDATA_W - IN_BITS){1'b0}}, loc_col, loc_chunk, loc_arch, id};
        do
            @(posedge clk);
        while (!s_axis_tready);
        // accepted at this edge; valid stays up for a possible back-to-back item
        r = apply_slot_command(cmd, id, loc_arch, loc_chunk, loc_col);
        pending_replies = {pending_replies, r};
        items_sent++;
        if (r.status == ST_NO_CHUNK)
            full_count++;
        else if (r.status == ST_BAD_LOC)
            bad_loc_count++;
        else if (cmd == CMD_ADD)
            placed_count++;
        else
            removed_count++;
        if (r.moved)
            swap_count++;
    endtask

    // shorthand for adds and removes with the unused fields randomized
    task automatic add_entity(input logic [ENTITY_W-1:0] id);
        logic [31:0] junk;
        junk = $urandom;
        send_command(CMD_ADD, id, junk[15:0], junk[19:16], junk[25:20]);
    endtask

    task automatic remove_at(input logic [ARCH_W-1:0] loc_arch,
                             input logic [CHUNK_W-1:0] loc_chunk,
                             input logic [COL_W-1:0] loc_col);
        send_command(CMD_REMOVE, $urandom, loc_arch, loc_chunk, loc_col);
    endtask

    // register write with the stream quiet and every reply collected
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        // each item has exactly one reply, so an empty queue leaves the core idle
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CAPACITY)
            cap_reg = value[CAP_W-1:0];
        else
            arch_reg = value[ARCH_W-1:0];
    endtask

    // receiver: ready drops at random at the current idle rate
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // reply checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin
        slot_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", m_axis_tdata, 64'd0);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch("status", 64'(m_axis_tdata[1:0]), 64'(want.status));
                if (m_axis_tdata[17:2] !== want.arch)
                    report_mismatch("out_archetype", 64'(m_axis_tdata[17:2]),
                                    64'(want.arch));
                if (m_axis_tdata[21:18] !== want.chunk)
                    report_mismatch("out_chunk", 64'(m_axis_tdata[21:18]), 64'(want.chunk));
                if (m_axis_tdata[27:22] !== want.column)
                    report_mismatch("out_column", 64'(m_axis_tdata[27:22]),
                                    64'(want.column));
                if (m_axis_tdata[28] !== want.moved)
                    report_mismatch("moved_valid", 64'(m_axis_tdata[28]), 64'(want.moved));
                if (m_axis_tdata[60:29] !== want.moved_id)
                    report_mismatch("moved_entity", 64'(m_axis_tdata[60:29]),
                                    64'(want.moved_id));
            end
        end
    end

    // fill, swap-remove, last-column remove and each kind of bad location
    task automatic test_swap_remove;
        write_register(REG_CAPACITY, 16'd2);
        write_register(REG_ARCHETYPE, 16'hFFFF);
        add_entity(32'hFFFF_FFFF);          // opens chunk 0
        add_entity(32'h0000_0000);          // fills chunk 0, popped
        add_entity(32'h5A5A_5A5A);          // opens chunk 1
        remove_at(16'hFFFF, 4'd0, 6'd0);    // last entity swapped into column 0
        remove_at(16'h0000, 4'd0, 6'd0);    // wrong archetype
        remove_at(16'hFFFF, 4'd15, 6'd0);   // chunk never opened
        remove_at(16'hFFFF, 4'd1, 6'd63);   // column past the fill
        remove_at(16'hFFFF, 4'd0, 6'd0);    // removing the last column moves nothing
        add_entity(32'h1234_5678);
    endtask

    // capacity extremes, stale stack top after a capacity drop
    task automatic test_capacity_extremes;
        write_register(REG_CAPACITY, 16'd64);
        add_entity(32'hA5A5_0001);
        add_entity(32'hA5A5_0002);
        add_entity(32'hA5A5_0003);
        // chunks on the stack now hold at least the new capacity
        write_register(REG_CAPACITY, 16'd1);
        add_entity(32'hDEAD_0001);
        add_entity(32'hDEAD_0002);
        write_register(REG_CAPACITY, 16'd0);
        add_entity(32'hC0DE_0001);
        // upper register bits set: saturates at the column count
        write_register(REG_CAPACITY, 16'hFF7F);
        add_entity(32'h8000_0000);
        add_entity(32'h0000_0001);
        remove_at(16'hFFFF, 4'd3, 6'd0);
        write_register(REG_ARCHETYPE, 16'h0000);
        remove_at(16'h0000, 4'd3, 6'd0);
    endtask

    // one random item: mostly adds and valid removes, some bad locations
    task automatic send_random_item(input int add_pct);
        int          r;
        int          ch;
        int          kind;
        int          live [$];
        logic [31:0] rnd;
        r = $urandom_range(99);
        rnd = $urandom;
        for (int c = 0; c < chunks_used; c++)
            if (fill_count[c] > 0)
                live = {live, c};
        if (r < add_pct)
        begin
            add_entity($urandom);
        end
        else if (r < 90 && live.size() > 0)
        begin
            ch = live[$urandom_range(live.size() - 1)];
            remove_at(arch_reg, CHUNK_W'(ch), COL_W'($urandom_range(fill_count[ch] - 1)));
        end
        else
        begin
            kind = $urandom_range(2);
            ch = $urandom_range(MAX_CHUNKS - 1);
            if (kind == 1)
                remove_at(arch_reg ^ (rnd[15:0] | 16'h0001), rnd[19:16], rnd[25:20]);
            else if (kind == 2 && fill_count[ch] < MAX_COLUMNS)
                remove_at(arch_reg, CHUNK_W'(ch),
                          COL_W'($urandom_range(MAX_COLUMNS - 1, fill_count[ch])));
            else
                remove_at(rnd[15:0], rnd[19:16], rnd[25:20]);
        end
    endtask

    // random phases, each with a fresh capacity and sometimes a new archetype
    task automatic test_random_traffic;
        int          sel;
        int          cap;
        logic [31:0] rnd;
        for (int phase = 0; phase < 12; phase++)
        begin
            // sender-light, then receiver-light, then no idling at all
            if (phase < 4)
            begin
                tx_idle_pct = 12;
                rx_idle_pct = 57;
            end
            else if (phase < 8)
            begin
                tx_idle_pct = 57;
                rx_idle_pct = 12;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            sel = $urandom_range(9);
            if (sel == 0)
                cap = 0;
            else if (sel == 1)
                cap = MAX_COLUMNS;
            else if (sel == 2)
                cap = 127;
            else if (sel < 5)
                cap = $urandom_range(MAX_COLUMNS, 33);
            else
                cap = $urandom_range(6, 1);
            rnd = $urandom;
            write_register(REG_CAPACITY, {rnd[8:0], 7'(cap)});
            if ($urandom_range(2) == 0)
                write_register(REG_ARCHETYPE, rnd[31:16]);
            sel = $urandom_range(65, 40);
            repeat (92) send_random_item(sel);
        end
    endtask

    // main sequence
    initial
    begin
        error_count = 0;
        items_sent = 0;
        placed_count = 0;
        removed_count = 0;
        swap_count = 0;
        full_count = 0;
        bad_loc_count = 0;
        cap_reg = CAPACITY_RESET;
        arch_reg = '0;
        open_depth = 0;
        chunks_used = 0;
        for (int c = 0; c < MAX_CHUNKS; c++)
        begin
            fill_count[c] = 0;
            open_stack[c] = 0;
        end
        tx_idle_pct = 12;
        rx_idle_pct = 57;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_swap_remove();
        test_capacity_extremes();
        test_random_traffic();

        // drain: all replies in, then a wait for anything stray
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d items: %0d placed, %0d removed (%0d with a swap)",
                 items_sent, placed_count, removed_count, swap_count);
        $display("out-of-space replies %0d, bad-location replies %0d, %0d chunks opened",
                 full_count, bad_loc_count, chunks_used);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- chunked_slot_allocator_swap_remove_core.f -----
+incdir+rtl
rtl/csa_pkg.sv
rtl/csa_ram.sv
rtl/chunked_slot_allocator_swap_remove_core.sv
verif/chunked_slot_allocator_swap_remove_core_tb.sv
